### src/bpa_pkg.sv
// shared constants, codes and helper functions for the buddy page allocator
package bpa_pkg;

	localparam int LOG_PAGES_DEF = 10;

	localparam int KIND_W  = 1;
	localparam int COUNT_W = 11;
	localparam int PAGE_W  = 20;
	localparam int STAT_W  = 2;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic REG_REGION = 1'b0;
	localparam logic REG_BASE   = 1'b1;

	localparam logic [COUNT_W-1:0] REGION_RST = 11'd1024;
	localparam logic [PAGE_W-1:0]  BASE_RST   = 20'd0;

	// index of the highest set bit, zero for zero
	function automatic logic [3:0] msb_idx(input logic [COUNT_W-1:0] v);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (v[i]) r = 4'(i);
		end
		return r;
	endfunction

	// smallest order whose block holds n pages
	function automatic logic [3:0] up_order(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] m;
		m = n - COUNT_W'(1);
		if (n <= COUNT_W'(1)) return 4'd0;
		return msb_idx(m) + 4'd1;
	endfunction

endpackage

### src/bpa_if.sv
// request and response channel interfaces
interface bpa_req_if import bpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [COUNT_W-1:0] page_count;
	logic [PAGE_W-1:0]  block_page;

	modport source (output valid, kind, page_count, block_page, input ready);
	modport sink (input valid, kind, page_count, block_page, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [PAGE_W-1:0]  granted_page;
	logic [COUNT_W-1:0] granted_pages;
	logic [COUNT_W-1:0] avail_pages;

	modport source (output valid, status, granted_page, granted_pages, avail_pages,
		input ready);
	modport sink (input valid, status, granted_page, granted_pages, avail_pages,
		output ready);
endinterface

### src/bpa_ram.sv
// generic simple dual-port ram with registered read
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### src/buddy_page_allocator_core.sv
// buddy page allocator: per-page state in one ram, free lists walked by a sequencer
// one item at a time; an allocate pops a block and splits it down one level per pass,
// a free pushes the block and merges it with its buddy upward one level per pass,
// and each then hands off its result through a holding register
// reset (arst_n low) and every register write start a clearing pass over every
// word of the page ram; no request is taken until it ends
module buddy_page_allocator_core import bpa_pkg::*; #(
	parameter int LOG_PAGES = LOG_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bpa_req_if.sink     req,
	bpa_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NP = 1 << LOG_PAGES;
	localparam int LW = LOG_PAGES + 1;              // link width, NP means none
	localparam int CW = LOG_PAGES + 1;              // page count width
	localparam int OW = ($clog2(LOG_PAGES + 1) > 4) ? $clog2(LOG_PAGES + 1) : 4;
	localparam int HB = ($clog2(LOG_PAGES + 1) > 0) ? $clog2(LOG_PAGES + 1) : 1;
	localparam logic [LW-1:0] NONE = LW'(NP);
	localparam int RP_RST = (32'(REGION_RST) > NP) ? NP : 32'(REGION_RST);
	localparam logic [OW-1:0] TOP_RST = (32'(REGION_RST) > NP) ?
		OW'(LOG_PAGES) : OW'(msb_idx(REGION_RST));

	// one ram word per page
	typedef struct packed {
		logic          fr;
		logic          us;
		logic [OW-1:0] ord;
		logic [LW-1:0] nx;
		logic [LW-1:0] pv;
	} ent_t;

	localparam logic [4:0]
		S_IDLE = 5'd0, S_CLEAR = 5'd1, S_RESP = 5'd2,
		S_A_SPLIT = 5'd3, S_A_POP = 5'd4, S_A_PUSHA = 5'd5, S_A_PUSHB = 5'd6,
		S_A_DONE = 5'd7,
		S_F_R = 5'd8, S_F_C = 5'd9, S_F_M = 5'd10, S_F_B = 5'd11, S_F_U2 = 5'd12,
		S_F_P = 5'd13, S_F_DONE = 5'd14,
		S_PU_W = 5'd15, S_PU_R = 5'd16, S_PU_M = 5'd17,
		S_UN_R = 5'd18, S_UN_D = 5'd19, S_UN_PR = 5'd20, S_UN_PM = 5'd21,
		S_UN_NR = 5'd22, S_UN_NM = 5'd23;

	// configuration and global state
	logic [COUNT_W-1:0] region_q;
	logic [PAGE_W-1:0]  base_q;
	logic [OW-1:0]      top_q;
	logic [CW-1:0]      fc_q;
	logic               rz_q;
	logic [LW-1:0]      heads_q [0:LOG_PAGES];

	// sequencer
	logic [4:0]           st_q, ret_q;
	logic [LOG_PAGES-1:0] clr_q;
	logic [OW-1:0]        o_q, i_q, op_o_q;
	logic [LOG_PAGES-1:0] op_p_q, rel_q, bud_q;
	logic [LW-1:0]        h_q, nx_q, pv_q;
	logic                 mark_q;
	logic [PAGE_W-1:0]    bp_q;

	// response holding register
	logic               ov_q;
	logic [STAT_W-1:0]  rs_st_q, out_st_q;
	logic [PAGE_W-1:0]  rs_pg_q, out_pg_q;
	logic [COUNT_W-1:0] rs_np_q, out_np_q, out_fp_q;

	// ram port
	logic                 ram_we;
	logic [LOG_PAGES-1:0] ram_waddr, ram_raddr;
	ent_t                 ram_wdata, rd;
	logic [$bits(ent_t)-1:0] ram_rdata;

	bpa_ram #(.WIDTH($bits(ent_t)), .DEPTH(NP)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
	assign rd = ent_t'(ram_rdata);

	// configuration port
	logic               cfg_wr, cfg_idx;
	logic [COUNT_W-1:0] region_n;
	logic [PAGE_W-1:0]  base_n;
	logic [OW-1:0]      top_n;
	logic [CW-1:0]      fc_n;
	logic               rz_n;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[2];
	assign cfg_wr  = psel & penable & pwrite;
	assign prdata  = (cfg_idx == REG_REGION) ? 32'(region_q) : 32'(base_q);

	always_comb begin
		region_n = region_q;
		base_n   = base_q;
		if (cfg_idx == REG_REGION) region_n = pwdata[COUNT_W-1:0];
		else base_n = pwdata[PAGE_W-1:0];
		rz_n  = (region_n == '0);
		top_n = (32'(region_n) > NP) ? OW'(LOG_PAGES) : OW'(msb_idx(region_n));
		fc_n  = rz_n ? '0 : (CW'(1) << top_n);
	end

	// request decode in idle
	logic [OW-1:0]        req_o, fnd_o;
	logic                 fnd, a_fail, f_fail;
	logic [PAGE_W-1:0]    rel_full;
	logic [LW-1:0]        hd;
	logic [LOG_PAGES-1:0] bud_c, lo_c;

	always_comb begin
		req_o = OW'(up_order(req.page_count));
		fnd   = 1'b0;
		fnd_o = '0;
		for (int k = 0; k <= LOG_PAGES; k++) begin
			if (!fnd && OW'(k) >= req_o && OW'(k) <= top_q && heads_q[k] != NONE) begin
				fnd   = 1'b1;
				fnd_o = OW'(k);
			end
		end
		a_fail = (req.page_count == '0) || (32'(req.page_count) > 32'(fc_q)) ||
			(req_o > top_q) || !fnd;
		rel_full = req.block_page - base_q;
		f_fail = (req.page_count == '0) || (32'(rel_full) >= (32'd1 << top_q)) || rz_q;
	end

	assign hd    = heads_q[op_o_q[HB-1:0]];
	assign bud_c = op_p_q ^ (LOG_PAGES'(1) << op_o_q);
	assign lo_c  = (rel_q < bud_q) ? rel_q : bud_q;

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = op_p_q;
		ram_wdata = rd;
		ram_raddr = op_p_q;
		case (st_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == '0 && !rz_q) begin
					ram_wdata.fr  = 1'b1;
					ram_wdata.ord = top_q;
					ram_wdata.nx  = NONE;
					ram_wdata.pv  = NONE;
				end
			end
			S_PU_W: begin
				ram_we        = 1'b1;
				ram_wdata.fr  = 1'b1;
				ram_wdata.us  = 1'b0;
				ram_wdata.ord = op_o_q;
				ram_wdata.nx  = hd;
				ram_wdata.pv  = NONE;
			end
			S_PU_R: ram_raddr = h_q[LOG_PAGES-1:0];
			S_PU_M: begin
				ram_we       = 1'b1;
				ram_waddr    = h_q[LOG_PAGES-1:0];
				ram_wdata.pv = LW'(op_p_q);
			end
			S_UN_D: begin
				ram_we       = 1'b1;
				ram_wdata.fr = 1'b0;
				if (mark_q) begin
					ram_wdata.us  = 1'b1;
					ram_wdata.ord = op_o_q;
				end
			end
			S_UN_PR: ram_raddr = pv_q[LOG_PAGES-1:0];
			S_UN_PM: begin
				ram_we       = 1'b1;
				ram_waddr    = pv_q[LOG_PAGES-1:0];
				ram_wdata.nx = nx_q;
			end
			S_UN_NR: ram_raddr = nx_q[LOG_PAGES-1:0];
			S_UN_NM: begin
				ram_we       = 1'b1;
				ram_waddr    = nx_q[LOG_PAGES-1:0];
				ram_wdata.pv = pv_q;
			end
			S_F_R: ram_raddr = rel_q;
			S_F_M: ram_raddr = bud_c;
			default: ;
		endcase
	end

	assign req.ready = (st_q == S_IDLE);

	assign rsp.valid         = ov_q;
	assign rsp.status        = out_st_q;
	assign rsp.granted_page  = out_pg_q;
	assign rsp.granted_pages = out_np_q;
	assign rsp.avail_pages   = out_fp_q;

	// payload-only registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				o_q     <= req_o;
				i_q     <= fnd_o;
				bp_q    <= req.block_page;
				rel_q   <= rel_full[LOG_PAGES-1:0];
				rs_pg_q <= '0;
				rs_np_q <= '0;
				rs_st_q <= (req.kind == KIND_ALLOC) ? ST_NO_SPACE : ST_BAD_FREE;
			end
			S_A_DONE: begin
				rs_st_q <= ST_OK;
				rs_pg_q <= base_q + PAGE_W'(op_p_q);
				rs_np_q <= COUNT_W'(CW'(1) << o_q);
			end
			S_A_PUSHB: i_q <= i_q - OW'(1);
			S_F_C: if (!(rd.us && rd.ord == o_q)) rs_st_q <= ST_BAD_FREE;
			S_F_M: bud_q <= bud_c;
			S_F_P: rel_q <= lo_c;
			S_F_DONE: begin
				rs_st_q <= ST_OK;
				rs_pg_q <= bp_q;
				rs_np_q <= COUNT_W'(CW'(1) << o_q);
			end
			S_PU_W: h_q <= hd;
			S_UN_D: begin
				nx_q <= rd.nx;
				pv_q <= rd.pv;
			end
			S_RESP: if (!ov_q || rsp.ready) begin
				out_st_q <= rs_st_q;
				out_pg_q <= rs_pg_q;
				out_np_q <= rs_np_q;
				out_fp_q <= COUNT_W'(fc_q);
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			ret_q    <= S_IDLE;
			clr_q    <= '0;
			region_q <= REGION_RST;
			base_q   <= BASE_RST;
			top_q    <= TOP_RST;
			fc_q     <= CW'(RP_RST > 0 ? (1 << TOP_RST) : 0);
			rz_q     <= (REGION_RST == '0);
			for (int k = 0; k <= LOG_PAGES; k++) begin
				heads_q[k] <= (OW'(k) == TOP_RST && REGION_RST != '0) ? '0 : NONE;
			end
			op_o_q   <= '0;
			op_p_q   <= '0;
			mark_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			// result valid: set when a result is handed off, dropped after its transfer
			if (st_q == S_RESP && (!ov_q || rsp.ready)) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;

			// a register write rebuilds the configuration and free lists and restarts the clearing pass
			if (cfg_wr) begin
				region_q <= region_n;
				base_q   <= base_n;
				top_q    <= top_n;
				fc_q     <= fc_n;
				rz_q     <= rz_n;
				for (int k = 0; k <= LOG_PAGES; k++) begin
					heads_q[k] <= (OW'(k) == top_n && !rz_n) ? '0 : NONE;
				end
				clr_q  <= '0;
				mark_q <= 1'b0;
				st_q   <= S_CLEAR;
			end else begin
				case (st_q)
					S_CLEAR: begin
						clr_q <= clr_q + LOG_PAGES'(1);
						if (clr_q == LOG_PAGES'(NP - 1)) st_q <= S_IDLE;
					end
					S_IDLE: if (req.valid) begin
						if (req.kind == KIND_ALLOC) st_q <= a_fail ? S_RESP : S_A_SPLIT;
						else st_q <= f_fail ? S_RESP : S_F_R;
					end
					// walk down from the found order, one split per pass
					S_A_SPLIT: begin
						mark_q <= !(i_q > o_q);
						op_o_q <= (i_q > o_q) ? i_q : o_q;
						st_q   <= S_A_POP;
					end
					S_A_POP: begin
						op_p_q <= hd[LOG_PAGES-1:0];
						ret_q  <= mark_q ? S_A_DONE : S_A_PUSHA;
						st_q   <= S_UN_R;
					end
					S_A_PUSHA: begin
						op_o_q <= op_o_q - OW'(1);
						ret_q  <= S_A_PUSHB;
						st_q   <= S_PU_W;
					end
					// upper half pushed last, so it is popped next
					S_A_PUSHB: begin
						op_p_q <= op_p_q + (LOG_PAGES'(1) << op_o_q);
						ret_q  <= S_A_SPLIT;
						st_q   <= S_PU_W;
					end
					S_A_DONE: begin
						mark_q <= 1'b0;
						fc_q   <= fc_q - (CW'(1) << o_q);
						st_q   <= S_RESP;
					end
					S_F_R: st_q <= S_F_C;
					S_F_C: begin
						if (rd.us && rd.ord == o_q) begin
							op_o_q <= o_q;
							op_p_q <= rel_q;
							mark_q <= 1'b0;
							ret_q  <= S_F_M;
							st_q   <= S_PU_W;
						end else begin
							st_q <= S_RESP;
						end
					end
					// merge with the buddy while it is a free head of this order
					S_F_M: st_q <= (op_o_q < top_q) ? S_F_B : S_F_DONE;
					S_F_B: begin
						if (rd.fr && rd.ord == op_o_q) begin
							ret_q <= S_F_U2;
							st_q  <= S_UN_R;
						end else begin
							st_q <= S_F_DONE;
						end
					end
					S_F_U2: begin
						op_p_q <= bud_q;
						ret_q  <= S_F_P;
						st_q   <= S_UN_R;
					end
					S_F_P: begin
						op_p_q <= lo_c;
						op_o_q <= op_o_q + OW'(1);
						ret_q  <= S_F_M;
						st_q   <= S_PU_W;
					end
					S_F_DONE: begin
						fc_q <= fc_q + (CW'(1) << o_q);
						st_q <= S_RESP;
					end
					// push op_p onto list op_o
					S_PU_W: begin
						heads_q[op_o_q[HB-1:0]] <= LW'(op_p_q);
						st_q <= (hd != NONE) ? S_PU_R : ret_q;
					end
					S_PU_R: st_q <= S_PU_M;
					S_PU_M: st_q <= ret_q;
					// unlink op_p from list op_o
					S_UN_R: st_q <= S_UN_D;
					S_UN_D: begin
						if (rd.pv == NONE) begin
							heads_q[op_o_q[HB-1:0]] <= rd.nx;
							st_q <= (rd.nx != NONE) ? S_UN_NR : ret_q;
						end else begin
							st_q <= S_UN_PR;
						end
					end
					S_UN_PR: st_q <= S_UN_PM;
					S_UN_PM: st_q <= (nx_q != NONE) ? S_UN_NR : ret_q;
					S_UN_NR: st_q <= S_UN_NM;
					S_UN_NM: st_q <= ret_q;
					S_RESP: if (!ov_q || rsp.ready) st_q <= S_IDLE;
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule

### sim/testbench.sv
// self-checking testbench for the buddy page allocator core
`timescale 1ns / 100ps

module testbench;
	import bpa_pkg::*;

	localparam int NPG  = 1 << LOG_PAGES_DEF;
	localparam int NORD = LOG_PAGES_DEF + 1;
	localparam logic [10:0] NIL = 11'(NPG);
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PAGE_W-1:0]  granted_page;
		logic [COUNT_W-1:0] granted_pages;
		logic [COUNT_W-1:0] avail_pages;
	} reply_t;

	typedef struct {
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] pages;
	} grant_t;

	// tracks the page map, predicts each reply and checks the replies in order
	class alloc_ledger;
		logic [COUNT_W-1:0] region_reg;
		logic [PAGE_W-1:0]  base_reg;
		logic [3:0]  blk_order [NPG];
		bit          is_free   [NPG];
		bit          is_used   [NPG];
		logic [10:0] nxt [NPG];
		logic [10:0] prv [NPG];
		logic [10:0] head [NORD];
		int unsigned free_cnt;
		int unsigned top;
		reply_t expected_replies[$];
		grant_t live_grants[$];
		int errors;

		function void push_blk(int unsigned o, int unsigned p);
			logic [10:0] h;
			h = head[o];
			prv[p] = NIL;
			nxt[p] = h;
			if (h != NIL) prv[h] = 11'(p);
			head[o] = 11'(p);
			is_free[p] = 1;
			blk_order[p] = 4'(o);
		endfunction

		function void unlink_blk(int unsigned o, int unsigned p);
			logic [10:0] n, v;
			n = nxt[p];
			v = prv[p];
			if (v == NIL) head[o] = n;
			else nxt[v] = n;
			if (n != NIL) prv[n] = v;
			is_free[p] = 0;
		endfunction

		function void rebuild();
			int unsigned rp;
			foreach (is_free[i]) begin
				is_free[i] = 0;
				is_used[i] = 0;
			end
			foreach (head[i]) head[i] = NIL;
			live_grants.delete();
			rp = region_reg;
			if (rp > NPG) rp = NPG;
			top = 0;
			free_cnt = 0;
			if (rp == 0) return;
			while (top < LOG_PAGES_DEF && (2 << top) <= rp) top++;
			free_cnt = 1 << top;
			push_blk(top, 0);
		endfunction

		function void init();
			region_reg = REGION_RST;
			base_reg = BASE_RST;
			errors = 0;
			rebuild();
		endfunction

		function void write_reg(logic idx, logic [31:0] val);
			if (idx == REG_REGION) region_reg = val[COUNT_W-1:0];
			else base_reg = val[PAGE_W-1:0];
			rebuild();
		endfunction

		function reply_t fail(logic [STAT_W-1:0] st);
			reply_t r;
			r.status = st;
			r.granted_page = '0;
			r.granted_pages = '0;
			r.avail_pages = COUNT_W'(free_cnt);
			return r;
		endfunction

		function reply_t predict(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] n,
				logic [PAGE_W-1:0] bp);
			int unsigned o, i, a, p, rel, cur, bud, lo;
			reply_t r;
			o = 0;
			while (o < 12 && (1 << o) < n) o++;
			if (kind == KIND_ALLOC) begin
				if (n == 0 || n > free_cnt || o > top) return fail(ST_NO_SPACE);
				i = o;
				while (i <= top && head[i] == NIL) i++;
				if (i > top) return fail(ST_NO_SPACE);
				// split down, upper half ends on top of the list
				while (i > o) begin
					a = head[i];
					unlink_blk(i, a);
					push_blk(i - 1, a);
					push_blk(i - 1, a + (1 << (i - 1)));
					i--;
				end
				p = head[o];
				unlink_blk(o, p);
				is_used[p] = 1;
				blk_order[p] = 4'(o);
				free_cnt -= 1 << o;
				r.status = ST_OK;
				r.granted_page = base_reg + PAGE_W'(p);
				r.granted_pages = COUNT_W'(1 << o);
				r.avail_pages = COUNT_W'(free_cnt);
				live_grants.push_back('{r.granted_page, r.granted_pages});
				return r;
			end
			rel = PAGE_W'(bp - base_reg);
			if (n == 0 || rel >= (1 << top) || region_reg == 0) return fail(ST_BAD_FREE);
			if (!is_used[rel] || blk_order[rel] != o) return fail(ST_BAD_FREE);
			is_used[rel] = 0;
			push_blk(o, rel);
			cur = o;
			// merge upward while the buddy is a free head of the same order
			while (cur < top) begin
				bud = rel ^ (1 << cur);
				if (!is_free[bud] || blk_order[bud] != cur) break;
				unlink_blk(cur, rel);
				unlink_blk(cur, bud);
				lo = rel < bud ? rel : bud;
				cur++;
				push_blk(cur, lo);
				rel = lo;
			end
			free_cnt += 1 << o;
			foreach (live_grants[k])
				if (live_grants[k].page == bp) begin
					live_grants.delete(k);
					break;
				end
			r.status = ST_OK;
			r.granted_page = bp;
			r.granted_pages = COUNT_W'(1 << o);
			r.avail_pages = COUNT_W'(free_cnt);
			return r;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] n,
				logic [PAGE_W-1:0] bp);
			expected_replies.push_back(predict(kind, n, bp));
		endfunction

		function void report_mismatch(string what, int got, int want);
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
			errors++;
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected reply status", got.status, -1);
				return;
			end
			want = expected_replies.pop_front();
			if (got.status != want.status)
				report_mismatch("status", got.status, want.status);
			if (got.granted_page != want.granted_page)
				report_mismatch("granted_page", got.granted_page, want.granted_page);
			if (got.granted_pages != want.granted_pages)
				report_mismatch("granted_pages", got.granted_pages, want.granted_pages);
			if (got.avail_pages != want.avail_pages)
				report_mismatch("avail_pages", got.avail_pages, want.avail_pages);
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	bpa_req_if req ();
	bpa_rsp_if rsp ();

	buddy_page_allocator_core dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	alloc_ledger ledger;
	bit no_idle;      // phases with back-to-back transfers on both sides
	int quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// transfer monitors: predictions are taken at the accepting edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				ledger.note_request(req.kind, req.page_count, req.block_page);
			if (rsp.valid && rsp.ready)
				ledger.check_reply('{rsp.status, rsp.granted_page, rsp.granted_pages,
					rsp.avail_pages});
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver side: random stall before each reply transfer
	initial begin
		int gap;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap > 0) begin
				rsp.ready = 0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready = 1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// apb write: setup cycle, then access cycle
	task automatic reg_write(logic idx, logic [31:0] val);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		ledger.write_reg(idx, val);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	// one request transfer after a random gap
	task automatic send_item(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] n,
			logic [PAGE_W-1:0] bp);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req.valid = 0;
			repeat (gap) @(negedge clk);
		end
		req.valid = 1;
		req.kind = kind;
		req.page_count = n;
		req.block_page = bp;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic end_burst();
		req.valid = 0;
	endtask

	// free the most recent live grant, optionally with a corrupted size
	task automatic free_newest(bit wrong_size);
		grant_t g;
		if (ledger.live_grants.size() == 0) begin
			send_item(KIND_FREE, 11'd1, 20'd0);
			return;
		end
		g = ledger.live_grants[$];
		send_item(KIND_FREE, wrong_size ? COUNT_W'(g.pages * 2) : g.pages, g.page);
	endtask

	// wait for every reply, then let the block settle before a register write
	task automatic settle();
		end_burst();
		while (ledger.expected_replies.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function logic [KIND_W-1:0] KIND_KIND();
		return $urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC;
	endfunction

	task automatic random_item(int unsigned rp);
		int sel, k;
		grant_t g;
		logic [COUNT_W-1:0] cnt;
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			// mostly small requests so the map fragments and merges stay deep
			if ($urandom_range(0, 3) != 0)
				cnt = COUNT_W'($urandom_range(1, rp > 4 ? rp / 4 : 1));
			else
				cnt = COUNT_W'($urandom_range(1, rp > 0 ? rp : 1));
			send_item(KIND_ALLOC, cnt, PAGE_W'($urandom));
		end else if (sel < 88 && ledger.live_grants.size() != 0) begin
			// legal free of a random live block, count anywhere in its size class
			k = $urandom_range(0, ledger.live_grants.size() - 1);
			g = ledger.live_grants[k];
			cnt = g.pages > 1 ? COUNT_W'($urandom_range(g.pages / 2 + 1, g.pages)) : 11'd1;
			send_item(KIND_FREE, cnt, g.page);
		end else if (sel < 94) begin
			// mostly broken frees: double size, or a page offset by 0 to 3 from a live block's start
			if (ledger.live_grants.size() != 0) begin
				g = ledger.live_grants[$urandom_range(0, ledger.live_grants.size() - 1)];
				if ($urandom_range(0, 1))
					send_item(KIND_FREE, COUNT_W'(g.pages * 2), g.page);
				else
					send_item(KIND_FREE, g.pages, g.page + PAGE_W'($urandom_range(0, 3)));
			end else
				send_item(KIND_FREE, 11'd1, ledger.base_reg);
		end else begin
			send_item(KIND_KIND(), COUNT_W'($urandom), PAGE_W'($urandom));
		end
	endtask

	task automatic run_phase(logic [COUNT_W-1:0] region, logic [PAGE_W-1:0] base,
			int items, bit quiet);
		int unsigned rp;
		settle();
		reg_write(REG_REGION, 32'(region));
		reg_write(REG_BASE, 32'(base));
		no_idle = quiet;
		rp = region > NPG ? NPG : region;
		repeat (items) random_item(rp);
	endtask

	initial begin
		ledger = new();
		ledger.init();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		req.valid = 0;
		req.kind = KIND_ALLOC;
		req.page_count = '0;
		req.block_page = '0;
		no_idle = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: split all the way, error replies, full merge, whole region
		send_item(KIND_ALLOC, 11'd1, 20'd0);
		send_item(KIND_ALLOC, 11'd0, 20'd0);
		send_item(KIND_ALLOC, 11'd2047, 20'hFFFFF);
		send_item(KIND_ALLOC, 11'd1024, 20'd0);
		send_item(KIND_FREE, 11'd0, 20'd1023);
		send_item(KIND_FREE, 11'd1, 20'd1024);
		send_item(KIND_FREE, 11'd1, 20'd1022);
		free_newest(1);
		free_newest(0);
		free_newest(0);
		send_item(KIND_ALLOC, 11'd1024, 20'd0);
		send_item(KIND_ALLOC, 11'd1, 20'd0);
		send_item(KIND_FREE, 11'd1000, 20'd0);
		send_item(KIND_ALLOC, 11'd3, 20'd0);
		send_item(KIND_ALLOC, 11'd2, 20'd0);
		send_item(KIND_ALLOC, 11'd1, 20'd0);
		send_item(KIND_ALLOC, 11'd513, 20'd0);
		free_newest(0);
		free_newest(0);
		free_newest(0);
		send_item(KIND_FREE, 11'd4, 20'hFFFFF);

		run_phase(11'd0, 20'd100, 20, 0);
		run_phase(11'd1, 20'd5, 40, 1);
		run_phase(11'd64, 20'hFFFF0, 250, 0);
		run_phase(11'd2047, 20'd12345, 300, 0);
		run_phase(11'd7, 20'd1047552, 120, 0);
		run_phase(11'd1024, 20'd0, 400, 1);
		run_phase(11'd100, 20'h55555, 200, 0);

		settle();
		if (ledger.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
src/bpa_pkg.sv
src/bpa_if.sv
src/bpa_ram.sv
src/buddy_page_allocator_core.sv
sim/testbench.sv
